// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame timing statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/ftsm_pkg.sv =====
// Types, constants and microcode program of the frame timing statistics monitor.
package ftsm_pkg;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int CNT_W   = 32;
    localparam int MEAN_W  = 56;
    localparam int LOG_W   = 16;
    localparam int STEP_W  = 5;

    // Result transaction layout: log_due, three counts, two means, byte padded
    localparam int OUT_RAW_W = 1 + 3 * CNT_W + 2 * MEAN_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [LOG_W-1:0] LOG_INTERVAL_RESET = 16'd300;

    // Clamp bounds of a Q sample, held one bit wider than the means
    localparam logic signed [MEAN_W:0] X_VAR_MAX  = (57'sd1 <<< (MEAN_W - 1)) - 57'sd1;
    localparam logic signed [MEAN_W:0] X_VAR_MIN  = -(57'sd1 <<< (MEAN_W - 1));
    localparam logic signed [MEAN_W:0] X_PROC_MAX = (57'sd1 <<< MEAN_W) - 57'sd1;

    // Event codes
    typedef enum logic [OP_W-1:0] {
        OP_RECEIVE = 3'd0,
        OP_SEND    = 3'd1,
        OP_START   = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_RESUME  = 3'd4,
        OP_END     = 3'd5
    } op_t;

    // Datapath actions selected by one control word
    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_MOD_START,
        ACT_RX_UPDATE,
        ACT_TX_UPDATE,
        ACT_VAR_PREP,
        ACT_VAR_DIFF,
        ACT_DIV_START,
        ACT_VAR_FOLD,
        ACT_PROC_START,
        ACT_PAUSE_DELTA,
        ACT_PAUSE_ACC,
        ACT_RESUME,
        ACT_PROC_PREP,
        ACT_PROC_DIFF,
        ACT_PROC_FOLD,
        ACT_EMIT
    } act_t;

    // Sequencer branch kinds
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_JUMP,
        BR_WAIT_IN,
        BR_WAIT_DIV,
        BR_WAIT_OUT,
        BR_NO_GAPS,
        BR_DISPATCH
    } br_t;

    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t S_FETCH     = 5'd0;
    localparam step_t S_DISPATCH  = 5'd1;
    localparam step_t S_RX_MOD    = 5'd2;
    localparam step_t S_RX_WAIT   = 5'd3;
    localparam step_t S_RX_UPD    = 5'd4;
    localparam step_t S_TX_UPD    = 5'd5;
    localparam step_t S_TX_CHK    = 5'd6;
    localparam step_t S_VAR_PREP  = 5'd7;
    localparam step_t S_VAR_DIFF  = 5'd8;
    localparam step_t S_VAR_DIV   = 5'd9;
    localparam step_t S_VAR_WAIT  = 5'd10;
    localparam step_t S_VAR_FOLD  = 5'd11;
    localparam step_t S_PSTART    = 5'd12;
    localparam step_t S_PAUSE     = 5'd13;
    localparam step_t S_PAUSE_ACC = 5'd14;
    localparam step_t S_RESUME    = 5'd15;
    localparam step_t S_END       = 5'd16;
    localparam step_t S_END_ACC   = 5'd17;
    localparam step_t S_PROC_PREP = 5'd18;
    localparam step_t S_PROC_DIFF = 5'd19;
    localparam step_t S_PROC_DIV  = 5'd20;
    localparam step_t S_PROC_WAIT = 5'd21;
    localparam step_t S_PROC_FOLD = 5'd22;
    localparam step_t S_EMIT      = 5'd23;

    typedef struct packed {
        act_t  act;
        br_t   br;
        step_t target;
    } uword_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic            in_fire;
        logic            div_done;
        logic            out_free;
        logic            no_gaps;
        logic [OP_W-1:0] op;
    } seq_status_t;

    // Microcode program
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        case (s)
            S_FETCH:     w = '{ACT_CAPTURE,     BR_WAIT_IN,  S_DISPATCH};
            S_DISPATCH:  w = '{ACT_NONE,        BR_DISPATCH, S_FETCH};
            S_RX_MOD:    w = '{ACT_MOD_START,   BR_NEXT,     S_FETCH};
            S_RX_WAIT:   w = '{ACT_NONE,        BR_WAIT_DIV, S_FETCH};
            S_RX_UPD:    w = '{ACT_RX_UPDATE,   BR_JUMP,     S_EMIT};
            S_TX_UPD:    w = '{ACT_TX_UPDATE,   BR_NEXT,     S_FETCH};
            S_TX_CHK:    w = '{ACT_NONE,        BR_NO_GAPS,  S_EMIT};
            S_VAR_PREP:  w = '{ACT_VAR_PREP,    BR_NEXT,     S_FETCH};
            S_VAR_DIFF:  w = '{ACT_VAR_DIFF,    BR_NEXT,     S_FETCH};
            S_VAR_DIV:   w = '{ACT_DIV_START,   BR_NEXT,     S_FETCH};
            S_VAR_WAIT:  w = '{ACT_NONE,        BR_WAIT_DIV, S_FETCH};
            S_VAR_FOLD:  w = '{ACT_VAR_FOLD,    BR_JUMP,     S_EMIT};
            S_PSTART:    w = '{ACT_PROC_START,  BR_JUMP,     S_EMIT};
            S_PAUSE:     w = '{ACT_PAUSE_DELTA, BR_NEXT,     S_FETCH};
            S_PAUSE_ACC: w = '{ACT_PAUSE_ACC,   BR_JUMP,     S_EMIT};
            S_RESUME:    w = '{ACT_RESUME,      BR_JUMP,     S_EMIT};
            S_END:       w = '{ACT_PAUSE_DELTA, BR_NEXT,     S_FETCH};
            S_END_ACC:   w = '{ACT_PAUSE_ACC,   BR_NEXT,     S_FETCH};
            S_PROC_PREP: w = '{ACT_PROC_PREP,   BR_NEXT,     S_FETCH};
            S_PROC_DIFF: w = '{ACT_PROC_DIFF,   BR_NEXT,     S_FETCH};
            S_PROC_DIV:  w = '{ACT_DIV_START,   BR_NEXT,     S_FETCH};
            S_PROC_WAIT: w = '{ACT_NONE,        BR_WAIT_DIV, S_FETCH};
            S_PROC_FOLD: w = '{ACT_PROC_FOLD,   BR_JUMP,     S_EMIT};
            S_EMIT:      w = '{ACT_EMIT,        BR_WAIT_OUT, S_FETCH};
            default:     w = '{ACT_NONE,        BR_JUMP,     S_FETCH};
        endcase
        return w;
    endfunction

    // Entry point of each event's routine; unknown codes only report
    function automatic step_t op_dispatch(input logic [OP_W-1:0] op);
        step_t s;
        case (op)
            OP_RECEIVE: s = S_RX_MOD;
            OP_SEND:    s = S_TX_UPD;
            OP_START:   s = S_PSTART;
            OP_PAUSE:   s = S_PAUSE;
            OP_RESUME:  s = S_RESUME;
            OP_END:     s = S_END;
            default:    s = S_EMIT;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/ftsm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module ftsm_div
    import ftsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MEAN_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              busy,
    output logic [MEAN_W-1:0] quotient,
    output logic [CNT_W-1:0]  remainder
);

    localparam int CNT_BITS = $clog2(MEAN_W + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [MEAN_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W:0]      rem_shift;
    logic [CNT_W:0]      trial;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        rem_shift = {rem_reg, quo_reg[MEAN_W-1]};
        trial     = rem_shift - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next = CNT_BITS'(MEAN_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[CNT_W]) begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[MEAN_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[MEAN_W-2:0], 1'b0};
            end
        end
    end

    // Hold iteration count under reset, payload free running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/ftsm_seq.sv =====
// Microcode sequencer: step counter, program table and branch logic.
module ftsm_seq
    import ftsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output uword_t      ctrl
);

    step_t step_reg, step_next;

    // Fetch the control word of the current step
    assign ctrl = ucode_rom(step_reg);

    // Pick the next step from the branch field
    always_comb begin
        step_next = step_reg;
        case (ctrl.br)
            BR_NEXT:     step_next = step_reg + 1'b1;
            BR_JUMP:     step_next = ctrl.target;
            BR_WAIT_IN:  if (status.in_fire) step_next = step_reg + 1'b1;
            BR_WAIT_DIV: if (status.div_done) step_next = step_reg + 1'b1;
            BR_WAIT_OUT: if (status.out_free) step_next = ctrl.target;
            BR_NO_GAPS:  step_next = status.no_gaps ? ctrl.target : step_reg + 1'b1;
            BR_DISPATCH: step_next = op_dispatch(status.op);
            default:     step_next = S_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hdl/frame_timing_stats_monitor_unit.sv =====
// Top level of the frame timing statistics monitor: datapath, sequencer, divider.
//
// Channel   | Direction | Handshake                 | Content
// s_axis    | in        | s_axis_tvalid/tready      | event code and timestamp
// m_axis    | out       | m_axis_tvalid/tready      | log flag, counts, two Q means
// cfg       | in        | cfg_valid/cfg_ready       | log_interval (16 bit)
//
// One event at a time. Receive, send with a variance update, and end all use the
// shared bit-serial divider (modulo on receive, mean update on send and end);
// other events do not use it.
// A finished result waits in the output register; the next event is taken while
// it waits, and the routine stalls only at its own emit step until the slot frees.
// aresetn is synchronous, active low; no clearing pass follows it.
`include "assert_macros.svh"

module frame_timing_stats_monitor_unit
    import ftsm_pkg::*;
#(
    parameter int TIME_BITS = 48,
    parameter int FRAC_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // [2:0] operation, [TIME_BITS+2:3] timestamp_us, rest zero
    input  logic [((OP_W + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [0] log_due, [32:1] received_total, [64:33] sent_total,
    // [96:65] skipped_total, [152:97] avg_gap_variance_q8,
    // [208:153] avg_process_q8, rest zero
    output logic [OUT_W-1:0]           m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [LOG_W-1:0]           cfg_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready
);

    localparam logic signed [64:0] VAR_HI  = (65'sd1 <<< (MEAN_W - 1 - FRAC_BITS)) - 65'sd1;
    localparam logic signed [64:0] VAR_LO  = -(65'sd1 <<< (MEAN_W - 1 - FRAC_BITS));
    localparam logic [64:0]        PROC_HI = (65'd1 << (MEAN_W - FRAC_BITS)) - 65'd1;

    uword_t      ctrl;
    seq_status_t status;

    logic              in_fire;
    logic              out_free;
    logic              div_start;
    logic              div_busy;
    logic [MEAN_W-1:0] div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic [MEAN_W-1:0] div_quo;
    logic [CNT_W-1:0]  div_rem;

    logic [OP_W-1:0]      op_reg, op_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [LOG_W-1:0]     log_interval_reg, log_interval_next;
    logic [TIME_BITS-1:0] last_rx_reg, last_rx_next;
    logic [TIME_BITS-1:0] rx_gap_reg, rx_gap_next;
    logic [TIME_BITS-1:0] last_tx_reg, last_tx_next;
    logic [TIME_BITS-1:0] tx_gap_reg, tx_gap_next;
    logic [TIME_BITS-1:0] pstart_reg, pstart_next;
    logic [TIME_BITS-1:0] pelapsed_reg, pelapsed_next;
    logic [TIME_BITS-1:0] pdelta_reg, pdelta_next;
    logic [MEAN_W-1:0]    var_mean_reg, var_mean_next;
    logic [CNT_W-1:0]     var_samples_reg, var_samples_next;
    logic [MEAN_W-1:0]    proc_mean_reg, proc_mean_next;
    logic [CNT_W-1:0]     proc_samples_reg, proc_samples_next;
    logic [CNT_W-1:0]     rx_count_reg, rx_count_next;
    logic [CNT_W-1:0]     tx_count_reg, tx_count_next;
    logic signed [MEAN_W:0]   x_reg, x_next;
    logic signed [MEAN_W+1:0] diff_reg, diff_next;
    logic                 neg_reg, neg_next;
    logic                 log_due_reg, log_due_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    logic signed [TIME_BITS:0] delta;
    logic signed [64:0]        delta_ext;
    logic signed [64:0]        var_scaled;
    logic [64:0]               elapsed_ext;
    logic [64:0]               proc_scaled;
    logic [MEAN_W+1:0]         diff_mag;
    logic [TIME_BITS:0]        pacc;

    // Handshakes
    assign s_axis_tready = (ctrl.act == ACT_CAPTURE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Status toward the sequencer
    assign status.in_fire  = in_fire;
    assign status.div_done = !div_busy;
    assign status.out_free = out_free;
    assign status.no_gaps  = (tx_gap_reg == '0) || (rx_gap_reg == '0);
    assign status.op       = op_reg;

    ftsm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Divider operands: modulo for the log flag, mean step otherwise
    assign div_start = (ctrl.act == ACT_MOD_START) || (ctrl.act == ACT_DIV_START);
    assign diff_mag  = diff_reg[MEAN_W+1] ? ((MEAN_W + 2)'(0) - diff_reg) : diff_reg;

    always_comb begin
        if (ctrl.act == ACT_MOD_START) begin
            div_dividend = MEAN_W'(rx_count_reg);
            div_divisor  = CNT_W'(log_interval_reg);
        end else begin
            div_dividend = diff_mag[MEAN_W-1:0];
            div_divisor  = (op_reg == OP_END) ? proc_samples_reg : var_samples_reg;
        end
    end

    ftsm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Scale and clamp the samples into Q form
    always_comb begin
        delta       = $signed({1'b0, tx_gap_reg}) - $signed({1'b0, rx_gap_reg});
        delta_ext   = {{(64 - TIME_BITS){delta[TIME_BITS]}}, delta};
        var_scaled  = delta_ext <<< FRAC_BITS;
        elapsed_ext = {{(65 - TIME_BITS){1'b0}}, pelapsed_reg};
        proc_scaled = elapsed_ext << FRAC_BITS;
        pacc        = {1'b0, pelapsed_reg} + {1'b0, pdelta_reg};
    end

    // Datapath actions
    always_comb begin
        op_next           = op_reg;
        now_next          = now_reg;
        log_interval_next = log_interval_reg;
        last_rx_next      = last_rx_reg;
        rx_gap_next       = rx_gap_reg;
        last_tx_next      = last_tx_reg;
        tx_gap_next       = tx_gap_reg;
        pstart_next       = pstart_reg;
        pelapsed_next     = pelapsed_reg;
        pdelta_next       = pdelta_reg;
        var_mean_next     = var_mean_reg;
        var_samples_next  = var_samples_reg;
        proc_mean_next    = proc_mean_reg;
        proc_samples_next = proc_samples_reg;
        rx_count_next     = rx_count_reg;
        tx_count_next     = tx_count_reg;
        x_next            = x_reg;
        diff_next         = diff_reg;
        neg_next          = neg_reg;
        log_due_next      = log_due_reg;
        m_tvalid_next     = m_tvalid_reg;
        out_data_next     = out_data_reg;

        if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            log_interval_next = cfg_data;
        end

        case (ctrl.act)
            ACT_CAPTURE: begin
                if (in_fire) begin
                    op_next      = s_axis_tdata[OP_W-1:0];
                    now_next     = s_axis_tdata[OP_W +: TIME_BITS];
                    log_due_next = 1'b0;
                end
            end
            ACT_RX_UPDATE: begin
                log_due_next  = (rx_count_reg != '0) && (log_interval_reg != '0) &&
                                (div_rem == '0);
                rx_count_next = rx_count_reg + 1'b1;
                if (last_rx_reg != '0) begin
                    rx_gap_next = now_reg - last_rx_reg;
                end
                last_rx_next = now_reg;
            end
            ACT_TX_UPDATE: begin
                tx_count_next = tx_count_reg + 1'b1;
                if (last_tx_reg != '0) begin
                    tx_gap_next = now_reg - last_tx_reg;
                end
                last_tx_next = now_reg;
            end
            ACT_VAR_PREP: begin
                if (delta_ext > VAR_HI) begin
                    x_next = X_VAR_MAX;
                end else if (delta_ext < VAR_LO) begin
                    x_next = X_VAR_MIN;
                end else begin
                    x_next = var_scaled[MEAN_W:0];
                end
                if (var_samples_reg != '1) begin
                    var_samples_next = var_samples_reg + 1'b1;
                end
            end
            ACT_VAR_DIFF: begin
                diff_next = {x_reg[MEAN_W], x_reg} -
                            {{2{var_mean_reg[MEAN_W-1]}}, var_mean_reg};
            end
            ACT_DIV_START: begin
                neg_next = diff_reg[MEAN_W+1];
            end
            ACT_VAR_FOLD: begin
                var_mean_next = neg_reg ? (var_mean_reg - div_quo) : (var_mean_reg + div_quo);
            end
            ACT_PROC_START: begin
                pstart_next   = now_reg;
                pelapsed_next = '0;
            end
            ACT_PAUSE_DELTA: begin
                // a stopped timer contributes nothing
                pdelta_next = (pstart_reg != '0) ? (now_reg - pstart_reg) : '0;
            end
            ACT_PAUSE_ACC: begin
                pelapsed_next = pacc[TIME_BITS] ? '1 : pacc[TIME_BITS-1:0];
                pstart_next   = '0;
            end
            ACT_RESUME: begin
                pstart_next = now_reg;
            end
            ACT_PROC_PREP: begin
                x_next = (elapsed_ext > PROC_HI) ? X_PROC_MAX : proc_scaled[MEAN_W:0];
                if (proc_samples_reg != '1) begin
                    proc_samples_next = proc_samples_reg + 1'b1;
                end
            end
            ACT_PROC_DIFF: begin
                diff_next = {x_reg[MEAN_W], x_reg} - {2'b00, proc_mean_reg};
            end
            ACT_PROC_FOLD: begin
                proc_mean_next = neg_reg ? (proc_mean_reg - div_quo)
                                         : (proc_mean_reg + div_quo);
            end
            ACT_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_data_next = OUT_W'({proc_mean_reg, var_mean_reg,
                                            rx_count_reg - tx_count_reg,
                                            tx_count_reg, rx_count_reg, log_due_reg});
                end
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_interval_reg <= LOG_INTERVAL_RESET;
            last_rx_reg      <= '0;
            rx_gap_reg       <= '0;
            last_tx_reg      <= '0;
            tx_gap_reg       <= '0;
            pstart_reg       <= '0;
            pelapsed_reg     <= '0;
            var_mean_reg     <= '0;
            var_samples_reg  <= '0;
            proc_mean_reg    <= '0;
            proc_samples_reg <= '0;
            rx_count_reg     <= '0;
            tx_count_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            log_interval_reg <= log_interval_next;
            last_rx_reg      <= last_rx_next;
            rx_gap_reg       <= rx_gap_next;
            last_tx_reg      <= last_tx_next;
            tx_gap_reg       <= tx_gap_next;
            pstart_reg       <= pstart_next;
            pelapsed_reg     <= pelapsed_next;
            var_mean_reg     <= var_mean_next;
            var_samples_reg  <= var_samples_next;
            proc_mean_reg    <= proc_mean_next;
            proc_samples_reg <= proc_samples_next;
            rx_count_reg     <= rx_count_next;
            tx_count_reg     <= tx_count_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Working registers of the current event
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        pdelta_reg   <= pdelta_next;
        x_reg        <= x_next;
        diff_reg     <= diff_next;
        neg_reg      <= neg_next;
        log_due_reg  <= log_due_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_IMPL(a_div_start_idle, aclk, aresetn, div_start, !div_busy)
    `ASSERT_IMPL(a_fetch_div_idle, aclk, aresetn, s_axis_tready, !div_busy)
    `ASSERT_NEXT(a_one_event, aclk, aresetn, in_fire, !s_axis_tready)
    `ASSERT_NEXT(a_var_sat_holds, aclk, aresetn, var_samples_reg == '1, var_samples_reg == '1)

endmodule
